/* hw/rtl/bmem_pkg.sv */
// ----------------------------------------------------------------------------
// bmem_pkg: shared types and constants of the battery monitor
// Field widths, register indexes, register reset values and the queue depth.
// ----------------------------------------------------------------------------
package bmem_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_IDX_W  = 3;

  // Median queue between the window front end and the filter back end.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMA_ALPHA = 3'd0,
    CFG_WARMUP    = 3'd1,
    CFG_MV_GAIN   = 3'd2,
    CFG_MIN_MV    = 3'd3,
    CFG_PCT_GAIN  = 3'd4
  } bmem_cfg_idx_t;

  typedef struct packed {
    logic [15:0] ema_alpha_q16;
    logic [3:0]  warmup_medians;
    logic [21:0] mv_per_count_q16;
    logic [15:0] battery_min_mv;
    logic [15:0] percent_gain_q16;
  } bmem_cfg_t;

  localparam logic [15:0] RST_EMA_ALPHA = 16'd6554;
  localparam logic [3:0]  RST_WARMUP    = 4'd5;
  localparam logic [21:0] RST_MV_GAIN   = 22'd54390;
  localparam logic [15:0] RST_MIN_MV    = 16'd6000;
  localparam logic [15:0] RST_PCT_GAIN  = 16'd2731;

endpackage

/* hw/rtl/bmem_if.sv */
// ----------------------------------------------------------------------------
// bmem_if: valid/ready channels of the battery monitor
// Sample channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface bmem_in_if;
  logic                          valid;
  logic                          ready;
  logic [bmem_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bmem_out_if;
  logic                      valid;
  logic                      ready;
  logic [bmem_pkg::MV_W-1:0]  battery_mv;
  logic [bmem_pkg::PCT_W-1:0] charge_percent;

  modport source (output valid, output battery_mv, output charge_percent, input ready);
  modport sink   (input valid, input battery_mv, input charge_percent, output ready);
endinterface

/* hw/rtl/bmem_front.sv */
// ----------------------------------------------------------------------------
// bmem_front: sample window and median selection
// Shifts samples into the window and, once it is full, pushes one median
// per sample into the queue.
// ----------------------------------------------------------------------------
module bmem_front #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bmem_in_if.sink                       in_ch,
  output logic                          push,
  output logic [bmem_pkg::SAMPLE_W-1:0] push_median,
  input  logic                          q_full
);
  import bmem_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int RANK_W = $clog2(WINDOW_LEN);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
  localparam logic [RANK_W-1:0] MID_LO    = RANK_W'((WINDOW_LEN - 1) / 2);
  localparam logic [RANK_W-1:0] MID_HI    = RANK_W'(WINDOW_LEN / 2);

  logic [SAMPLE_W-1:0] win_r [WINDOW_LEN];
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                pend_r, pend_nxt;
  logic                accept;
  logic [RANK_W-1:0]   rank [WINDOW_LEN];
  logic [SAMPLE_W-1:0] val_lo, val_hi;
  logic [SAMPLE_W:0]   mid_sum;

  // A median waits in pend_r until the queue takes it; the window holds
  // still until then.
  assign in_ch.ready = !pend_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = pend_r && !q_full;

  always_comb begin
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    if (push) begin
      pend_nxt = 1'b0;
    end
    if (accept) begin
      if (fill_r != FILL_FULL) begin
        fill_nxt = fill_r + 1'b1;
      end
      pend_nxt = (fill_nxt == FILL_FULL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= in_ch.adc_sample;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // Each entry's sorted position: the entries below it, with ties broken
  // by slot order, so that every position is taken exactly once.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if ((win_r[j] < win_r[i]) || ((win_r[j] == win_r[i]) && (j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  // For an odd window both middle positions are the same entry.
  always_comb begin
    val_lo = '0;
    val_hi = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      val_lo = val_lo | ((rank[i] == MID_LO) ? win_r[i] : '0);
      val_hi = val_hi | ((rank[i] == MID_HI) ? win_r[i] : '0);
    end
  end

  assign mid_sum     = {1'b0, val_lo} + {1'b0, val_hi};
  assign push_median = mid_sum[SAMPLE_W:1];

endmodule

/* hw/rtl/bmem_fifo.sv */
// ----------------------------------------------------------------------------
// bmem_fifo: median queue
// Short first-in first-out buffer that decouples window and filter.
// ----------------------------------------------------------------------------
module bmem_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [bmem_pkg::SAMPLE_W-1:0] push_data,
  output logic                          full,
  input  logic                          pop,
  output logic                          pop_valid,
  output logic [bmem_pkg::SAMPLE_W-1:0] pop_data
);
  import bmem_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [SAMPLE_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wptr_r, rptr_r;
  logic [CNT_W-1:0]    count_r;
  logic                do_push, do_pop;

  assign full      = (count_r == CNT_FULL);
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/bmem_back.sv */
// ----------------------------------------------------------------------------
// bmem_back: EMA, block average and scaling
// Sequencer around one shared multiplier: EMA of each median, block sum,
// average by reciprocal multiplication, millivolt and percent scaling.
// ----------------------------------------------------------------------------
module bmem_back #(
  parameter int AVG_BLOCK = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmem_pkg::bmem_cfg_t           cfg,
  input  logic                          q_valid,
  input  logic [bmem_pkg::SAMPLE_W-1:0] q_data,
  output logic                          pop,
  bmem_out_if.source                    out_ch
);
  import bmem_pkg::*;

  localparam int EMA_W   = 20;
  localparam int SUM_W   = 25;
  localparam int ACC_W   = 37;
  localparam int TALLY_W = 5;
  localparam int BFILL_W = $clog2(AVG_BLOCK + 1);
  localparam int DIV_S   = 26;
  localparam int DIVX_W  = 26;
  localparam int RECIP_W = 27;
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((64'd1 << DIV_S) / AVG_BLOCK);
  localparam logic [DIVX_W-1:0]  DIVISOR   = DIVX_W'(AVG_BLOCK);
  localparam logic [DIVX_W-1:0]  HALF      = DIVX_W'(AVG_BLOCK / 2);
  localparam logic [BFILL_W-1:0] BFILL_END = BFILL_W'(AVG_BLOCK - 1);
  localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(16);
  localparam logic [16:0]        ONE_Q16   = 17'h10000;
  localparam logic [PCT_W-1:0]   PCT_MAX   = PCT_W'(100);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMA_A,
    S_EMA_B,
    S_EMA_SUM,
    S_DIV_MUL,
    S_DIV_FIX,
    S_MV_MUL,
    S_MV_SAT,
    S_PCT_MUL,
    S_OUT
  } state_t;

  state_t               state_r;
  logic [TALLY_W-1:0]   tally_r, tally_inc;
  logic [EMA_W-1:0]     ema_r, ema_new;
  logic [SUM_W-1:0]     block_sum_r, block_total;
  logic [BFILL_W-1:0]   block_fill_r;
  logic                 out_valid_r;
  logic [MV_W-1:0]      out_mv_r;
  logic [PCT_W-1:0]     out_pct_r;

  logic [EMA_W-1:0]     med_r;
  logic                 warm_r, warm;
  logic [ACC_W-1:0]     acc_r, ema_sum;
  logic [DIVX_W-1:0]    div_x_r, div_prod, div_rem;
  logic [EMA_W-1:0]     q_est, avg_r;
  logic [MV_W-1:0]      mv_r, mv_diff;
  logic                 low_r;
  logic [42:0]          mv_sum;
  logic [18:0]          mv_wide;
  logic [32:0]          pct_sum;
  logic [16:0]          pct_wide;
  logic [PCT_W-1:0]     pct;
  logic                 out_free;

  logic                 mul_en;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod_r;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.battery_mv     = out_mv_r;
  assign out_ch.charge_percent = out_pct_r;

  assign pop       = (state_r == S_IDLE) && q_valid;
  assign tally_inc = (tally_r < TALLY_MAX) ? tally_r + 1'b1 : tally_r;
  assign warm      = (tally_inc <= {1'b0, cfg.warmup_medians});
  assign out_free  = !out_valid_r || out_ch.ready;

  // Shared multiplier: operands follow the sequencer step.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_EMA_A: begin
        mul_a = MUL_A_W'(cfg.ema_alpha_q16);
        mul_b = MUL_B_W'(med_r);
      end
      S_EMA_B: begin
        mul_a = MUL_A_W'(ONE_Q16 - {1'b0, cfg.ema_alpha_q16});
        mul_b = MUL_B_W'(ema_r);
      end
      S_DIV_MUL: begin
        mul_a = MUL_A_W'(RECIP);
        mul_b = div_x_r;
      end
      S_MV_MUL: begin
        mul_a = MUL_A_W'(cfg.mv_per_count_q16);
        mul_b = MUL_B_W'(avg_r);
      end
      S_PCT_MUL: begin
        mul_a = MUL_A_W'(cfg.percent_gain_q16);
        mul_b = MUL_B_W'(mv_diff);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign ema_sum     = acc_r + prod_r[ACC_W-1:0];
  assign ema_new     = warm_r ? med_r : ema_sum[35:16];
  assign block_total = block_sum_r + SUM_W'(ema_new);

  // The reciprocal estimate is at most one below the true quotient.
  assign q_est    = prod_r[DIV_S+EMA_W-1:DIV_S];
  assign div_prod = {6'd0, q_est} * DIVISOR;
  assign div_rem  = div_x_r - div_prod;

  assign mv_sum  = {1'b0, prod_r[41:0]} + 43'h800000;
  assign mv_wide = mv_sum[42:24];
  assign mv_diff = mv_r - cfg.battery_min_mv;

  assign pct_sum  = {1'b0, prod_r[31:0]} + 33'h8000;
  assign pct_wide = pct_sum[32:16];
  always_comb begin
    if (low_r) begin
      pct = '0;
    end else if (pct_wide > 17'(PCT_MAX)) begin
      pct = PCT_MAX;
    end else begin
      pct = pct_wide[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tally_r      <= '0;
      ema_r        <= '0;
      block_sum_r  <= '0;
      block_fill_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            tally_r <= tally_inc;
            state_r <= warm ? S_EMA_SUM : S_EMA_A;
          end
        end
        S_EMA_A: state_r <= S_EMA_B;
        S_EMA_B: state_r <= S_EMA_SUM;
        S_EMA_SUM: begin
          ema_r <= ema_new;
          if (block_fill_r == BFILL_END) begin
            block_sum_r  <= '0;
            block_fill_r <= '0;
            state_r      <= S_DIV_MUL;
          end else begin
            block_sum_r  <= block_total;
            block_fill_r <= block_fill_r + 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_DIV_MUL: state_r <= S_DIV_FIX;
        S_DIV_FIX: state_r <= S_MV_MUL;
        S_MV_MUL:  state_r <= S_MV_SAT;
        S_MV_SAT:  state_r <= S_PCT_MUL;
        S_PCT_MUL: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_mv_r    <= mv_r;
            out_pct_r   <= pct;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (pop) begin
      med_r  <= {q_data, 8'h00};
      warm_r <= warm;
    end
    if (state_r == S_EMA_B) begin
      acc_r <= prod_r[ACC_W-1:0] + ACC_W'(32768);
    end
    if (state_r == S_EMA_SUM) begin
      div_x_r <= {1'b0, block_total} + HALF;
    end
    if (state_r == S_DIV_FIX) begin
      avg_r <= (div_rem >= DIVISOR) ? q_est + 1'b1 : q_est;
    end
    if (state_r == S_MV_SAT) begin
      mv_r <= (mv_wide[18:16] != 3'd0) ? {MV_W{1'b1}} : mv_wide[MV_W-1:0];
    end
    if (state_r == S_PCT_MUL) begin
      low_r <= (mv_r <= cfg.battery_min_mv);
    end
  end

`ifndef NO_ASSERTIONS
  a_block_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(block_fill_r) < AVG_BLOCK)
    else $error("block fill count passed the block length");

  a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_block_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_MUL) |-> (block_fill_r == '0) && (block_sum_r == '0))
    else $error("block state not cleared after a finished block");

  a_recip_error: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_FIX) |-> (div_rem < (DIVISOR << 1)))
    else $error("reciprocal quotient off by more than one");
`endif

endmodule

/* hw/rtl/battery_median_ema_monitor_core.sv */
// ----------------------------------------------------------------------------
// battery_median_ema_monitor_core: battery voltage and charge monitor
// Median-of-window filter, EMA, block average, millivolt and percent output.
// ----------------------------------------------------------------------------
// The window front end takes one ADC sample per cycle while its median queue
// has room; the first WINDOW_LEN-1 samples after reset only fill the window.
// The filter back end takes a median after warm-up through the queue pop,
// two passes of its shared multiplier for the EMA and the update, a warm-up
// median through the pop and update only, and pops no new median before it
// is idle again, so it sets the sustained rate. The sample that completes a
// block of AVG_BLOCK filtered values goes on to the average by reciprocal
// multiply and correction, millivolt and percent scaling, and then waits
// until the output register is free. One result (battery_mv, charge_percent)
// leaves per block. The user must write registers through cfg_we/cfg_index/
// cfg_data only while no sample is in flight; the block does not enforce it.
module battery_median_ema_monitor_core #(
  parameter int WINDOW_LEN = 5,
  parameter int AVG_BLOCK  = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bmem_in_if.sink                         in_ch,
  bmem_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bmem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmem_pkg::*;

  bmem_cfg_t           cfg_r;
  logic                push, q_full, q_valid, pop;
  logic [SAMPLE_W-1:0] push_median, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_alpha_q16    <= RST_EMA_ALPHA;
      cfg_r.warmup_medians   <= RST_WARMUP;
      cfg_r.mv_per_count_q16 <= RST_MV_GAIN;
      cfg_r.battery_min_mv   <= RST_MIN_MV;
      cfg_r.percent_gain_q16 <= RST_PCT_GAIN;
    end else if (cfg_we) begin
      unique case (bmem_cfg_idx_t'(cfg_index))
        CFG_EMA_ALPHA: cfg_r.ema_alpha_q16    <= cfg_data[15:0];
        CFG_WARMUP:    cfg_r.warmup_medians   <= cfg_data[3:0];
        CFG_MV_GAIN:   cfg_r.mv_per_count_q16 <= cfg_data[21:0];
        CFG_MIN_MV:    cfg_r.battery_min_mv   <= cfg_data[15:0];
        CFG_PCT_GAIN:  cfg_r.percent_gain_q16 <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  bmem_front #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .push        (push),
    .push_median (push_median),
    .q_full      (q_full)
  );

  bmem_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_median),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  bmem_back #(
    .AVG_BLOCK (AVG_BLOCK)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for battery_median_ema_monitor_core
// Streams ADC samples through the valid/ready channels while a bit-exact
// filter model predicts every block result (median, EMA, block average,
// millivolt and percent scaling). Registers are reprogrammed between phases,
// both channel sides idle at random, and one long output hold-off backs the
// block up into its input.
// ----------------------------------------------------------------------------
module tb;
  import bmem_pkg::*;

  localparam int WINDOW_LEN = 5;
  localparam int AVG_BLOCK  = 10;

  localparam int unsigned IDLE_CYCLES  = 64;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam int CFG_UNUSED_LO = 5;
  localparam int CFG_UNUSED_HI = 2 ** CFG_IDX_W - 1;

  localparam logic [21:0] NOMINAL_MV_GAIN  = 22'd262144;
  localparam logic [15:0] NOMINAL_MIN_MV   = 16'd6000;
  localparam logic [15:0] NOMINAL_PCT_GAIN = 16'd1092;

  typedef enum {SAMPLES_UNIFORM, SAMPLES_DRIFT, SAMPLES_RAIL} sample_style_t;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
  } batt_result_t;

  typedef struct {
    logic [SAMPLE_W-1:0] win [WINDOW_LEN];
    int unsigned         slot;
    int unsigned         fill;
    int unsigned         tally;
    logic [19:0]         ema;
    logic [24:0]         bsum;
    int unsigned         bfill;
  } filt_state_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bmem_in_if  in_ch ();
  bmem_out_if out_ch ();

  battery_median_ema_monitor_core #(
    .WINDOW_LEN(WINDOW_LEN),
    .AVG_BLOCK (AVG_BLOCK)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  filt_state_t  model;
  bmem_cfg_t    cfg_model;
  batt_result_t expected_results [$];
  batt_result_t oldest_result;
  int           errors = 0;

  bit          gaps_on = 1'b1;
  int unsigned burst_left = 0;
  bit          rx_stalls = 1'b1;
  int unsigned rx_run = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Bit-exact model of one sample; returns 1 when the sample closes a block.
  function automatic bit filter_sample(inout filt_state_t st, input bmem_cfg_t c,
                                       input logic [SAMPLE_W-1:0] s,
                                       output batt_result_t r);
    logic [SAMPLE_W-1:0] sorted [WINDOW_LEN];
    logic [SAMPLE_W-1:0] v;
    logic [19:0]         med_q8;
    int unsigned         med;
    longint unsigned     acc, avg, mv, pct;
    int                  j;
    r = '0;
    st.win[st.slot] = s;
    st.slot = (st.slot + 1) % WINDOW_LEN;
    if (st.fill < WINDOW_LEN) st.fill++;
    if (st.fill < WINDOW_LEN) return 1'b0;

    sorted = st.win;
    for (int i = 1; i < WINDOW_LEN; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    if (WINDOW_LEN % 2 == 0) begin
      med = (int'(sorted[WINDOW_LEN/2-1]) + int'(sorted[WINDOW_LEN/2])) >> 1;
    end else begin
      med = sorted[WINDOW_LEN/2];
    end
    med_q8 = 20'(med << 8);

    if (st.tally < 16) st.tally++;
    if (st.tally <= c.warmup_medians) begin
      st.ema = med_q8;
    end else begin
      acc = 64'(c.ema_alpha_q16) * 64'(med_q8)
          + (64'd65536 - 64'(c.ema_alpha_q16)) * 64'(st.ema) + 64'd32768;
      st.ema = 20'(acc >> 16);
    end

    st.bsum = st.bsum + 25'(st.ema);
    st.bfill++;
    if (st.bfill < AVG_BLOCK) return 1'b0;

    avg = (64'(st.bsum) + AVG_BLOCK / 2) / AVG_BLOCK;
    st.bsum = '0;
    st.bfill = 0;
    mv = (avg * 64'(c.mv_per_count_q16) + (64'd1 << 23)) >> 24;
    if (mv > 65535) mv = 65535;
    if (mv <= 64'(c.battery_min_mv)) begin
      pct = 0;
    end else begin
      pct = ((mv - 64'(c.battery_min_mv)) * 64'(c.percent_gain_q16) + 64'd32768) >> 16;
      if (pct > 100) pct = 100;
    end
    r.mv  = MV_W'(mv);
    r.pct = PCT_W'(pct);
    return 1'b1;
  endfunction

  function automatic int unsigned pick_value(int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // A sample around a slowly moving level, with an occasional spike that the
  // median should reject.
  function automatic logic [SAMPLE_W-1:0] level_sample(int unsigned level, int unsigned noise);
    int unsigned lo, hi;
    if ($urandom_range(0, 15) == 0) return SAMPLE_W'($urandom_range(0, 4095));
    lo = (level > noise) ? level - noise : 0;
    hi = (level + noise > 4095) ? 4095 : level + noise;
    return SAMPLE_W'($urandom_range(lo, hi));
  endfunction

  // Result checker: every accepted result is matched against the oldest
  // outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: battery_mv %0d charge_percent %0d",
               out_ch.battery_mv, out_ch.charge_percent);
        errors++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_ch.battery_mv !== oldest_result.mv) begin
          $error("battery_mv: expected %0d, got %0d", oldest_result.mv, out_ch.battery_mv);
          errors++;
        end
        if (out_ch.charge_percent !== oldest_result.pct) begin
          $error("charge_percent: expected %0d, got %0d",
                 oldest_result.pct, out_ch.charge_percent);
          errors++;
        end
      end
    end
  end

  // Result receiver: random stall runs, optional always-ready stretches and a
  // long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!rx_stalls) begin
      out_ch.ready <= 1'b1;
    end else if (rx_run != 0) begin
      rx_run <= rx_run - 1;
    end else begin
      out_ch.ready <= 1'($urandom_range(0, 1));
      rx_run <= $urandom_range(0, 6);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    batt_result_t r;
    if (gaps_on && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left != 0) burst_left--;
    if (filter_sample(model, cfg_model, s, r)) expected_results.push_back(r);
  endtask

  task automatic wait_idle;
    int unsigned waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
      expected_results.delete();
    end
    // Samples that close no block may still be in flight.
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_EMA_ALPHA: cfg_model.ema_alpha_q16    = data[15:0];
      CFG_WARMUP:    cfg_model.warmup_medians   = data[3:0];
      CFG_MV_GAIN:   cfg_model.mv_per_count_q16 = data[21:0];
      CFG_MIN_MV:    cfg_model.battery_min_mv   = data[15:0];
      CFG_PCT_GAIN:  cfg_model.percent_gain_q16 = data[15:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry junk, and one write goes to an index past
  // the register list, which must change nothing.
  task automatic program_regs(input logic [15:0] alpha, input logic [3:0] warmup,
                              input logic [21:0] mv_gain, input logic [15:0] min_mv,
                              input logic [15:0] pct_gain);
    write_reg(CFG_EMA_ALPHA, {6'($urandom), alpha});
    write_reg(CFG_WARMUP, {18'($urandom), warmup});
    write_reg(CFG_MV_GAIN, mv_gain);
    write_reg(CFG_MIN_MV, {6'($urandom), min_mv});
    write_reg(CFG_PCT_GAIN, {6'($urandom), pct_gain});
    write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic run_samples(input int unsigned count, input sample_style_t style);
    int unsigned         level, stride;
    logic [SAMPLE_W-1:0] s;
    level = $urandom_range(0, 4095);
    repeat (count) begin
      case (style)
        SAMPLES_UNIFORM: s = SAMPLE_W'($urandom_range(0, 4095));
        SAMPLES_RAIL:    s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        default: begin
          stride = $urandom_range(0, 64);
          if ($urandom_range(0, 1)) level = (level + stride > 4095) ? 4095 : level + stride;
          else level = (level > stride) ? level - stride : 0;
          s = level_sample(level, 24);
        end
      endcase
      send_sample(s);
    end
  endtask

  // Registers left at their reset values; rail-to-rail samples.
  task automatic test_reset_defaults;
    logic [SAMPLE_W-1:0] seq [14] = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0,
                                      12'd2048, 12'd1, 12'd4094, 12'd2047, 12'd4095,
                                      12'd4095, 12'd0, 12'd1234};
    foreach (seq[i]) send_sample(seq[i]);
    wait_idle();
  endtask

  // No warm-up, full alpha and maximum gains: millivolts saturate and the
  // percentage clamps.
  task automatic test_saturation;
    program_regs(16'hFFFF, 4'd0, 22'h3FFFFF, 16'd0, 16'hFFFF);
    repeat (AVG_BLOCK) send_sample(12'hFFF);
    wait_idle();
  endtask

  // The minimum is set to the exact millivolt value of the coming block, then
  // one below it, so both sides of the zero-percent edge are hit.
  task automatic test_min_boundary;
    filt_state_t         trial;
    bmem_cfg_t           probe;
    batt_result_t        r;
    logic [SAMPLE_W-1:0] plan [AVG_BLOCK];
    int unsigned         n, level;
    logic [15:0]         mv_hit;
    for (int k = 0; k < 2; k++) begin
      level = $urandom_range(500, 3500);
      n = AVG_BLOCK - model.bfill;
      for (int i = 0; i < n; i++) plan[i] = level_sample(level, 8);
      probe = cfg_model;
      probe.ema_alpha_q16 = 16'hFFFF;
      probe.mv_per_count_q16 = NOMINAL_MV_GAIN;
      trial = model;
      mv_hit = '0;
      for (int i = 0; i < n; i++) begin
        if (filter_sample(trial, probe, plan[i], r)) mv_hit = r.mv;
      end
      program_regs(16'hFFFF, probe.warmup_medians, NOMINAL_MV_GAIN, mv_hit - 16'(k), 16'hFFFF);
      for (int i = 0; i < n; i++) send_sample(plan[i]);
      wait_idle();
    end
  endtask

  // Frozen EMA, longest warm-up, zero gains and the highest minimum.
  task automatic test_zero_gains;
    program_regs(16'd0, 4'd15, 22'd0, 16'hFFFF, 16'd0);
    run_samples(40, SAMPLES_UNIFORM);
    wait_idle();
  endtask

  task automatic test_nominal;
    program_regs(RST_EMA_ALPHA, RST_WARMUP, NOMINAL_MV_GAIN, NOMINAL_MIN_MV, NOMINAL_PCT_GAIN);
    run_samples(150, SAMPLES_DRIFT);
    run_samples(50, SAMPLES_UNIFORM);
    wait_idle();
  endtask

  task automatic test_random_settings;
    logic [21:0]     gain;
    longint unsigned top;
    logic [15:0]     min_mv, pct_gain;
    repeat (5) begin
      gain = $urandom_range(0, 1) ? 22'(pick_value(22'h3FFFFF))
                                  : 22'($urandom_range(16384, 524288));
      top = (64'd4095 * 64'(gain)) >> 16;
      if (top > 65535) top = 65535;
      min_mv = $urandom_range(0, 1) ? 16'(pick_value(65535))
                                    : 16'($urandom_range(0, int'(top)));
      pct_gain = $urandom_range(0, 1) ? 16'(pick_value(65535))
                                      : 16'($urandom_range(200, 5000));
      program_regs(16'(pick_value(65535)), 4'($urandom_range(0, 15)), gain, min_mv, pct_gain);
      gaps_on = ($urandom_range(0, 3) != 0);
      rx_stalls <= ($urandom_range(0, 3) != 0);
      run_samples(60, sample_style_t'($urandom_range(0, 2)));
      wait_idle();
    end
  endtask

  // The receiver holds off while samples keep coming, so the median queue
  // fills and the block has to stall its input.
  task automatic test_backpressure;
    program_regs(RST_EMA_ALPHA, RST_WARMUP, NOMINAL_MV_GAIN, NOMINAL_MIN_MV, NOMINAL_PCT_GAIN);
    gaps_on = 1'b0;
    rx_stalls <= 1'b0;
    hold_req <= hold_req + 1;
    run_samples(60, SAMPLES_DRIFT);
    wait_idle();
    gaps_on = 1'b1;
    rx_stalls <= 1'b1;
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.adc_sample <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;

    cfg_model.ema_alpha_q16    = RST_EMA_ALPHA;
    cfg_model.warmup_medians   = RST_WARMUP;
    cfg_model.mv_per_count_q16 = RST_MV_GAIN;
    cfg_model.battery_min_mv   = RST_MIN_MV;
    cfg_model.percent_gain_q16 = RST_PCT_GAIN;
    foreach (model.win[i]) model.win[i] = '0;
    model.slot  = 0;
    model.fill  = 0;
    model.tally = 0;
    model.ema   = '0;
    model.bsum  = '0;
    model.bfill = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_saturation();
    test_min_boundary();
    test_zero_gains();
    test_nominal();
    test_random_settings();
    test_backpressure();
    wait_idle();

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
